// ===== design/pbtm_pkg.sv =====
package pbtm_pkg;

    // Window depth of the moving average.
    localparam int WINDOW = 10;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Field widths.
    localparam int LIMIT_W = 18;
    localparam int MV_W    = 15;
    localparam int MA_W    = 13;
    localparam int POWER_W = 19;
    localparam int CFG_W   = 16;

    // Power reading: product of voltage and current, then divided by 1000.
    // The division is an exact reciprocal multiply for every product below 2**PROD_W.
    localparam int     PROD_W = MV_W + MA_W;
    localparam longint MW_DIV = 1000;
    localparam int     MW_SH  = PROD_W + $clog2(MW_DIV);
    localparam int     MW_M_W = PROD_W + 1;
    localparam int     MW_P_W = PROD_W + MW_M_W;
    localparam logic [MW_M_W-1:0] MW_RECIP =
        MW_M_W'(((longint'(1) << MW_SH) + MW_DIV - 1) / MW_DIV);

    // Running sum of the window and its exact division by WINDOW.
    localparam int SUM_W   = POWER_W + $clog2(WINDOW);
    localparam int AVG_SH  = SUM_W + $clog2(WINDOW);
    localparam int AVG_M_W = SUM_W + 1;
    localparam int AVG_P_W = SUM_W + AVG_M_W;
    localparam logic [AVG_M_W-1:0] AVG_RECIP =
        AVG_M_W'(((longint'(1) << AVG_SH) + WINDOW - 1) / WINDOW);

    // Width of the threshold comparison: average plus two 16-bit terms.
    localparam int CMP_W = POWER_W + 1;

    // Register port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] LOW_RST  = CFG_W'(4000);
    localparam logic [CFG_W-1:0] HIGH_RST = CFG_W'(9000);
    localparam logic [CFG_W-1:0] GAIN_RST = CFG_W'(7500);

    typedef enum logic [APB_ADDR_W-3:0] {
        REG_LOW  = 2'd0,
        REG_HIGH = 2'd1,
        REG_GAIN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] low_mw;
        logic [CFG_W-1:0] high_mw;
        logic [CFG_W-1:0] gain_mw;
    } cfg_t;

    // Control fields of one tick that travel along the pipeline.
    typedef struct packed {
        logic               asleep;
        logic               sourcing;
        logic [LIMIT_W-1:0] limit_mw;
    } tick_t;

endpackage

// ===== design/pbtm_regs.sv =====
module pbtm_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pbtm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pbtm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pbtm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output pbtm_pkg::cfg_t                   cfg
);

    pbtm_pkg::cfg_t     cfg_reg;
    pbtm_pkg::cfg_t     cfg_next;
    pbtm_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = pbtm_pkg::reg_idx_t'(paddr[pbtm_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pbtm_pkg::REG_LOW:  cfg_next.low_mw  = pwdata[pbtm_pkg::CFG_W-1:0];
                pbtm_pkg::REG_HIGH: cfg_next.high_mw = pwdata[pbtm_pkg::CFG_W-1:0];
                pbtm_pkg::REG_GAIN: cfg_next.gain_mw = pwdata[pbtm_pkg::CFG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pbtm_pkg::REG_LOW:
                prdata = pbtm_pkg::APB_DATA_W'(cfg_reg.low_mw);
            pbtm_pkg::REG_HIGH:
                prdata = pbtm_pkg::APB_DATA_W'(cfg_reg.high_mw);
            pbtm_pkg::REG_GAIN:
                prdata = pbtm_pkg::APB_DATA_W'(cfg_reg.gain_mw);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_mw  <= pbtm_pkg::LOW_RST;
            cfg_reg.high_mw <= pbtm_pkg::HIGH_RST;
            cfg_reg.gain_mw <= pbtm_pkg::GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/pbtm_power.sv =====
module pbtm_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pbtm_pkg::tick_t                in_tick,
    input  logic [pbtm_pkg::MV_W-1:0]      in_mv,
    input  logic [pbtm_pkg::MA_W-1:0]      in_ma,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pbtm_pkg::tick_t                out_tick,
    output logic [pbtm_pkg::POWER_W-1:0]   out_power
);

    // Stage 1 holds the raw product, stage 2 the reading in milliwatts.
    logic                             s1_valid_reg, s1_valid_next;
    pbtm_pkg::tick_t                  s1_tick_reg;
    logic [pbtm_pkg::PROD_W-1:0]      s1_prod_reg, s1_prod_next;
    logic                             s2_valid_reg, s2_valid_next;
    pbtm_pkg::tick_t                  s2_tick_reg;
    logic [pbtm_pkg::POWER_W-1:0]     s2_power_reg, s2_power_next;
    logic [pbtm_pkg::MW_P_W-1:0]      scaled;
    logic                             s1_take, s2_take;

    assign s2_take  = !s2_valid_reg || out_ready;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign in_ready = s1_take;

    assign s1_prod_next = pbtm_pkg::PROD_W'(in_mv) * pbtm_pkg::PROD_W'(in_ma);

    // The quotient field is exactly POWER_W bits wide, so the reading can never
    // exceed the field maximum and no clamp is required.
    assign scaled = pbtm_pkg::MW_P_W'(s1_prod_reg) * pbtm_pkg::MW_P_W'(pbtm_pkg::MW_RECIP);
    assign s2_power_next = scaled[pbtm_pkg::MW_SH +: pbtm_pkg::POWER_W];

    always_comb
    begin
        s1_valid_next = s1_take ? in_valid : s1_valid_reg;
        s2_valid_next = s2_take ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && in_valid)
        begin
            s1_tick_reg <= in_tick;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_tick_reg  <= s1_tick_reg;
            s2_power_reg <= s2_power_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_tick  = s2_tick_reg;
    assign out_power = s2_power_reg;

    // The reciprocal multiply must give the truncated quotient by 1000.
    a_power_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |->
            (pbtm_pkg::MW_P_W'(s2_power_next) * pbtm_pkg::MW_P_W'(pbtm_pkg::MW_DIV)
                 <= pbtm_pkg::MW_P_W'(s1_prod_reg)) &&
            (pbtm_pkg::MW_P_W'(s1_prod_reg)
                 < pbtm_pkg::MW_P_W'(s2_power_next) * pbtm_pkg::MW_P_W'(pbtm_pkg::MW_DIV)
                   + pbtm_pkg::MW_P_W'(pbtm_pkg::MW_DIV)))
        else $error("power reading is not the truncated quotient by 1000");

endmodule

// ===== design/pbtm_window.sv =====
module pbtm_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pbtm_pkg::tick_t                in_tick,
    input  logic [pbtm_pkg::POWER_W-1:0]   in_power,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pbtm_pkg::tick_t                out_tick,
    output logic [pbtm_pkg::POWER_W-1:0]   out_avg
);

    // Window state, updated as each tick enters stage 3.
    logic [pbtm_pkg::POWER_W-1:0] win_reg  [pbtm_pkg::WINDOW];
    logic [pbtm_pkg::POWER_W-1:0] win_next [pbtm_pkg::WINDOW];
    logic [pbtm_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [pbtm_pkg::SUM_W-1:0]   sum_reg, sum_next;

    logic                             s3_valid_reg, s3_valid_next;
    pbtm_pkg::tick_t                  s3_tick_reg;
    logic [pbtm_pkg::SUM_W-1:0]       s3_sum_reg;
    logic                             s4_valid_reg, s4_valid_next;
    pbtm_pkg::tick_t                  s4_tick_reg;
    logic [pbtm_pkg::POWER_W-1:0]     s4_avg_reg, s4_avg_next;

    logic                             s3_take, s4_take, commit;
    logic                             in_compute, s3_compute;
    logic [pbtm_pkg::SUM_W-1:0]       refill_sum;
    logic [pbtm_pkg::AVG_P_W-1:0]     avg_scaled;
    logic [pbtm_pkg::POWER_W-1:0]     avg_q;
    logic [pbtm_pkg::SUM_W-1:0]       win_total;

    assign s4_take  = !s4_valid_reg || out_ready;
    assign s3_take  = !s3_valid_reg || s4_take;
    assign in_ready = s3_take;
    assign commit   = in_valid && s3_take;

    assign in_compute = !in_tick.asleep && (in_tick.limit_mw != '0);
    assign s3_compute = !s3_tick_reg.asleep && (s3_tick_reg.limit_mw != '0);
    assign refill_sum = pbtm_pkg::SUM_W'(pbtm_pkg::SUM_W'(in_power)
                                         * pbtm_pkg::SUM_W'(pbtm_pkg::WINDOW));

    always_comb
    begin
        win_next  = win_reg;
        slot_next = slot_reg;
        sum_next  = sum_reg;
        if (commit)
        begin
            if (in_tick.asleep)
            begin
                win_next[0] = '0;
                sum_next    = sum_reg - pbtm_pkg::SUM_W'(win_reg[0]);
            end
            else if (in_compute)
            begin
                if (win_reg[0] == '0)
                begin
                    // Empty window: every entry takes the current reading.
                    for (int i = 0; i < pbtm_pkg::WINDOW; i++)
                    begin
                        win_next[i] = in_power;
                    end
                    sum_next = refill_sum;
                end
                else
                begin
                    win_next[slot_reg] = in_power;
                    sum_next = sum_reg - pbtm_pkg::SUM_W'(win_reg[slot_reg])
                               + pbtm_pkg::SUM_W'(in_power);
                end
                slot_next = (slot_reg == pbtm_pkg::SLOT_W'(pbtm_pkg::WINDOW - 1))
                            ? '0 : slot_reg + 1'b1;
            end
        end
    end

    assign avg_scaled = pbtm_pkg::AVG_P_W'(s3_sum_reg)
                        * pbtm_pkg::AVG_P_W'(pbtm_pkg::AVG_RECIP);
    assign avg_q       = avg_scaled[pbtm_pkg::AVG_SH +: pbtm_pkg::POWER_W];
    assign s4_avg_next = s3_compute ? avg_q : '0;

    always_comb
    begin
        s3_valid_next = s3_take ? in_valid : s3_valid_reg;
        s4_valid_next = s4_take ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbtm_pkg::WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            slot_reg     <= '0;
            sum_reg      <= '0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg      <= win_next;
            slot_reg     <= slot_next;
            sum_reg      <= sum_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            s3_tick_reg <= in_tick;
            s3_sum_reg  <= sum_next;
        end
        if (s4_take && s3_valid_reg)
        begin
            s4_tick_reg <= s3_tick_reg;
            s4_avg_reg  <= s4_avg_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_tick  = s4_tick_reg;
    assign out_avg   = s4_avg_reg;

    always_comb
    begin
        win_total = '0;
        for (int i = 0; i < pbtm_pkg::WINDOW; i++)
        begin
            win_total = win_total + pbtm_pkg::SUM_W'(win_reg[i]);
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= pbtm_pkg::SLOT_W'(pbtm_pkg::WINDOW - 1))
        else $error("write slot left the window");

    a_sum_tracks_window: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg == win_total)
        else $error("running sum differs from the window contents");

    a_avg_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |->
            (pbtm_pkg::SUM_W'(avg_q) * pbtm_pkg::SUM_W'(pbtm_pkg::WINDOW) <= s3_sum_reg) &&
            (s3_sum_reg - pbtm_pkg::SUM_W'(avg_q) * pbtm_pkg::SUM_W'(pbtm_pkg::WINDOW)
                < pbtm_pkg::SUM_W'(pbtm_pkg::WINDOW)))
        else $error("average is not the truncated mean of the window");

endmodule

// ===== design/pbtm_decide.sv =====
module pbtm_decide (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pbtm_pkg::tick_t                in_tick,
    input  logic [pbtm_pkg::POWER_W-1:0]   in_avg,
    input  pbtm_pkg::cfg_t                 cfg,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           throttle,
    output logic                           changed,
    output logic [pbtm_pkg::POWER_W-1:0]   average_mw
);

    logic                          throttled_reg, throttled_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          throttle_reg;
    logic                          changed_reg, changed_next;
    logic [pbtm_pkg::POWER_W-1:0]  avg_reg;
    logic                          out_take, commit;
    logic [pbtm_pkg::CMP_W-1:0]    limit_ext, start_bound, stop_bound;
    logic                          decision;

    assign out_take = !out_valid_reg || out_ready;
    assign in_ready = out_take;
    assign commit   = in_valid && out_take;

    // gap < low  is  limit < avg + low;  gap - gain < high  is  limit < avg + gain + high.
    assign limit_ext   = pbtm_pkg::CMP_W'(in_tick.limit_mw);
    assign start_bound = pbtm_pkg::CMP_W'(in_avg) + pbtm_pkg::CMP_W'(cfg.low_mw);
    assign stop_bound  = pbtm_pkg::CMP_W'(in_avg) + pbtm_pkg::CMP_W'(cfg.gain_mw)
                         + pbtm_pkg::CMP_W'(cfg.high_mw);

    always_comb
    begin
        priority if (in_tick.asleep)
            decision = 1'b0;
        else if (in_tick.limit_mw == '0)
            decision = throttled_reg;
        else if (!in_tick.sourcing)
            decision = 1'b0;
        else if (throttled_reg)
            decision = limit_ext < stop_bound;
        else
            decision = limit_ext < start_bound;
    end

    always_comb
    begin
        throttled_next = commit ? decision : throttled_reg;
        changed_next   = decision ^ throttled_reg;
        out_valid_next = out_take ? in_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttled_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            throttled_reg <= throttled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            throttle_reg <= decision;
            changed_reg  <= changed_next;
            avg_reg      <= in_avg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign throttle   = throttle_reg;
    assign changed    = changed_reg;
    assign average_mw = avg_reg;

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (throttle_reg == throttled_reg))
        else $error("held result disagrees with the throttle state");

endmodule

// ===== design/power_budget_throttle_monitor_top.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// input    | in_valid/in_ready  | asleep, limit_mw[17:0], bus_mv[14:0],
//          |                    | input_ma[12:0], sourcing
// output   | out_valid/out_ready| throttle, changed, average_mw[18:0]
// config   | APB psel/penable   | paddr[3:0], pwdata[31:0], prdata[31:0], pready
//
// One transaction is accepted per cycle unless a stalled output has backed up to the input;
// the result of a tick reaches the output register through a six-deep register chain.
// Reset (rst_n low) empties the pipeline, clears the window, write slot and
// throttle state, and loads the threshold registers with their defaults.
// A stalled output only backs up through stages that hold data; empty stages
// keep accepting new transactions until the chain is full.
module power_budget_throttle_monitor_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pbtm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pbtm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pbtm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Tick input.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             asleep,
    input  logic [pbtm_pkg::LIMIT_W-1:0]     limit_mw,
    input  logic [pbtm_pkg::MV_W-1:0]        bus_mv,
    input  logic [pbtm_pkg::MA_W-1:0]        input_ma,
    input  logic                             sourcing,
    // Result output.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             throttle,
    output logic                             changed,
    output logic [pbtm_pkg::POWER_W-1:0]     average_mw
);

    // The pipeline is:
    //   stage 0  input register (this module)
    //   stage 1  voltage times current
    //   stage 2  division by 1000 through a reciprocal multiply
    //   stage 3  window update and running sum
    //   stage 4  division of the sum by the window depth
    //   stage 5  hysteresis decision and result register
    // Each piece of state is touched by exactly one stage, and ticks flow in
    // order, so a tick always sees the state left by the tick ahead of it.

    pbtm_pkg::cfg_t                  cfg;

    logic                            s0_valid_reg, s0_valid_next;
    pbtm_pkg::tick_t                 s0_tick_reg, s0_tick_next;
    logic [pbtm_pkg::MV_W-1:0]       s0_mv_reg;
    logic [pbtm_pkg::MA_W-1:0]       s0_ma_reg;
    logic                            s0_take;

    logic                            pw_ready;
    logic                            pw_valid;
    pbtm_pkg::tick_t                 pw_tick;
    logic [pbtm_pkg::POWER_W-1:0]    pw_power;

    logic                            win_ready;
    logic                            win_valid;
    pbtm_pkg::tick_t                 win_tick;
    logic [pbtm_pkg::POWER_W-1:0]    win_avg;

    logic                            dec_ready;

    // Threshold registers. Writes are expected only while the block is idle.
    pbtm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The input register is free whenever it is empty or its tick moves on.
    assign s0_take  = !s0_valid_reg || pw_ready;
    assign in_ready = s0_take;

    always_comb
    begin
        s0_tick_next.asleep   = asleep;
        s0_tick_next.sourcing = sourcing;
        s0_tick_next.limit_mw = limit_mw;
        s0_valid_next         = s0_take ? in_valid : s0_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_take && in_valid)
        begin
            s0_tick_reg <= s0_tick_next;
            s0_mv_reg   <= bus_mv;
            s0_ma_reg   <= input_ma;
        end
    end

    // Power reading in milliwatts.
    pbtm_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (pw_ready),
        .in_tick   (s0_tick_reg),
        .in_mv     (s0_mv_reg),
        .in_ma     (s0_ma_reg),
        .out_valid (pw_valid),
        .out_ready (win_ready),
        .out_tick  (pw_tick),
        .out_power (pw_power)
    );

    // Moving average over the window. Sleeping ticks clear the first entry,
    // ticks with an unknown limit leave the window alone and report zero.
    pbtm_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pw_valid),
        .in_ready  (win_ready),
        .in_tick   (pw_tick),
        .in_power  (pw_power),
        .out_valid (win_valid),
        .out_ready (dec_ready),
        .out_tick  (win_tick),
        .out_avg   (win_avg)
    );

    // Throttle decision with hysteresis and the result register.
    pbtm_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (win_valid),
        .in_ready   (dec_ready),
        .in_tick    (win_tick),
        .in_avg     (win_avg),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .throttle   (throttle),
        .changed    (changed),
        .average_mw (average_mw)
    );

endmodule
